// File: hdl/fdes_pkg.sv
package fdes_pkg;

    // Bytes in one cluster; the offset within a cluster wraps at this size.
    localparam int unsigned CLUSTER_BYTES = 65536;
    localparam logic [15:0] OFFSET_MASK   = 16'(CLUSTER_BYTES - 1);

    localparam logic [31:0] ENTRY_BYTES   = 32'd32;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
    // Above this value one more entry saturates the count.
    localparam logic [31:0] COUNT_SAT_AT  = COUNT_MAX - ENTRY_BYTES;

    localparam logic [7:0]  NAME_END      = 8'h00;
    localparam logic [7:0]  NAME_FREE     = 8'hE5;
    localparam int unsigned ATTR_VOLUME_BIT = 3;
    localparam int unsigned ATTR_DIR_BIT    = 4;
    localparam int unsigned HALF_BITS       = 16;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 64;

    localparam logic [63:0] NAME_BODY_RESET   = 64'h2020_2020_2020_2020;
    localparam logic [23:0] NAME_SUFFIX_RESET = 24'h20_2020;

    typedef enum logic [1:0] {
        REG_NAME_BODY   = 2'd0,
        REG_NAME_SUFFIX = 2'd1,
        REG_MATCH_ANY   = 2'd2
    } fdes_reg_t;

    typedef enum logic [2:0] {
        ST_FREE     = 3'd0,
        ST_NO_MATCH = 3'd1,
        ST_FOUND    = 3'd2,
        ST_END      = 3'd3,
        ST_IDLE     = 3'd4
    } fdes_status_t;

    typedef enum logic [1:0] {
        KIND_FILE   = 2'd0,
        KIND_DIR    = 2'd1,
        KIND_VOLUME = 2'd2
    } fdes_kind_t;

    typedef struct packed {
        logic        first_of_search;
        logic [63:0] entry_name_body;
        logic [23:0] entry_name_suffix;
        logic [7:0]  attributes;
        logic [15:0] start_cluster_high;
        logic [15:0] start_cluster_low;
        logic [31:0] entry_file_size;
        logic [27:0] holding_cluster;
        logic [15:0] entry_offset;
    } fdes_entry_t;

    typedef struct packed {
        fdes_status_t status;
        logic [31:0]  bytes_moved;
        logic [27:0]  found_cluster;
        logic [15:0]  found_offset;
        logic [1:0]   file_kind;
        logic [31:0]  first_cluster;
        logic [31:0]  found_size;
    } fdes_result_t;

    typedef struct packed {
        logic [63:0] name_body;
        logic [23:0] name_suffix;
        logic        match_any;
    } fdes_cfg_t;

endpackage

// File: hdl/fat_directory_entry_scanner_core.sv
// Channel   Direction  Handshake                   Payload
// entry     in         entry_valid / entry_stall   fdes_entry_t, one directory entry
// result    out        result_valid / result_stall fdes_result_t, one status beat
// config    in         APB psel/penable/pwrite     three search registers at 0x00/0x08/0x10
//
// One entry beat can be taken every cycle while entry_stall is low; its result
// beat passes through the entry register, then the result register, with one
// 88-bit name compare and one saturating 32-bit add between the two registers.
// Reset clears the running byte count, the done flag and both valid flags, and
// loads the default search registers (blank name, match any).
// A stalled result beat holds; entry_stall rises only when both stages are full.
module fat_directory_entry_scanner_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          entry_valid,
    output logic                          entry_stall,
    input  fdes_pkg::fdes_entry_t         entry,
    output logic                          result_valid,
    input  logic                          result_stall,
    output fdes_pkg::fdes_result_t        result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fdes_pkg::PADDR_W-1:0]  paddr,
    input  logic [fdes_pkg::PDATA_W-1:0]  pwdata,
    output logic [fdes_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import fdes_pkg::*;

    fdes_cfg_t    cfg;
    logic         stage_valid_reg;
    logic         stage_valid_next;
    fdes_entry_t  stage_entry_reg;
    logic         result_valid_reg;
    logic         result_valid_next;
    fdes_result_t result_reg;
    fdes_result_t eval_result;
    logic         advance;
    logic         take_entry;

    fdes_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held entry moves into the result register whenever that register is
    // empty or its beat is being taken this cycle. The search state updates on
    // the same edge, so the next entry sees what this one left behind.
    assign advance     = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign entry_stall = stage_valid_reg && !advance;
    assign take_entry  = entry_valid && !entry_stall;

    fdes_entry_eval u_entry_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .entry   (stage_entry_reg),
        .cfg     (cfg),
        .result  (eval_result)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take_entry)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take_entry)
            stage_entry_reg <= entry;
        if (advance)
            result_reg <= eval_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: hdl/fdes_cfg_regs.sv
module fdes_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fdes_pkg::PADDR_W-1:0]  paddr,
    input  logic [fdes_pkg::PDATA_W-1:0]  pwdata,
    output logic [fdes_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output fdes_pkg::fdes_cfg_t           cfg
);
    import fdes_pkg::*;

    fdes_cfg_t cfg_reg;
    fdes_cfg_t cfg_next;
    fdes_reg_t reg_sel;
    logic      wr_en;

    // Registers sit on 8-byte boundaries; the low address bits are ignored.
    assign reg_sel = fdes_reg_t'(paddr[4:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_NAME_BODY:   cfg_next.name_body   = pwdata[63:0];
                REG_NAME_SUFFIX: cfg_next.name_suffix = pwdata[23:0];
                REG_MATCH_ANY:   cfg_next.match_any   = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.name_body   <= NAME_BODY_RESET;
            cfg_reg.name_suffix <= NAME_SUFFIX_RESET;
            cfg_reg.match_any   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_NAME_BODY:   prdata = cfg_reg.name_body;
            REG_NAME_SUFFIX: prdata = {40'd0, cfg_reg.name_suffix};
            REG_MATCH_ANY:   prdata = {63'd0, cfg_reg.match_any};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/fdes_entry_eval.sv
module fdes_entry_eval (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  fdes_pkg::fdes_entry_t  entry,
    input  fdes_pkg::fdes_cfg_t    cfg,
    output fdes_pkg::fdes_result_t result
);
    import fdes_pkg::*;

    logic [31:0]  moved_count_reg;
    logic [31:0]  moved_count_next;
    logic         search_done_reg;
    logic         search_done_next;
    logic [31:0]  base_count;
    logic         base_done;
    logic [31:0]  added_count;
    logic [7:0]   first_byte;
    logic         name_hit;
    fdes_kind_t   kind;

    // A new search clears the count and the done flag before this entry.
    assign base_count  = entry.first_of_search ? '0 : moved_count_reg;
    assign base_done   = entry.first_of_search ? 1'b0 : search_done_reg;
    assign added_count = (base_count > COUNT_SAT_AT) ? COUNT_MAX : base_count + ENTRY_BYTES;
    assign first_byte  = entry.entry_name_body[63:56];
    assign name_hit    = cfg.match_any ||
                         ((entry.entry_name_body == cfg.name_body) &&
                          (entry.entry_name_suffix == cfg.name_suffix));

    // The volume label bit wins over the directory bit.
    always_comb
    begin
        if (entry.attributes[ATTR_VOLUME_BIT])
            kind = KIND_VOLUME;
        else if (entry.attributes[ATTR_DIR_BIT])
            kind = KIND_DIR;
        else
            kind = KIND_FILE;
    end

    always_comb
    begin
        moved_count_next = base_count;
        search_done_next = base_done;
        result           = '0;
        if (base_done)
        begin
            result.status = ST_IDLE;
        end
        else if (first_byte == NAME_END)
        begin
            result.status    = ST_END;
            search_done_next = 1'b1;
        end
        else if (first_byte == NAME_FREE)
        begin
            result.status    = ST_FREE;
            moved_count_next = added_count;
        end
        else if (name_hit)
        begin
            result.status        = ST_FOUND;
            moved_count_next     = added_count;
            search_done_next     = 1'b1;
            result.found_cluster = entry.holding_cluster;
            result.found_offset  = entry.entry_offset & OFFSET_MASK;
            result.file_kind     = kind;
            result.first_cluster = {entry.start_cluster_high, entry.start_cluster_low};
            result.found_size    = entry.entry_file_size;
        end
        else
        begin
            result.status    = ST_NO_MATCH;
            moved_count_next = added_count;
        end
        result.bytes_moved = moved_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moved_count_reg <= '0;
            search_done_reg <= 1'b0;
        end
        else if (advance)
        begin
            moved_count_reg <= moved_count_next;
            search_done_reg <= search_done_next;
        end
    end

endmodule

// File: hdl/fdes_checker.sv
module fdes_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_stall,
    input fdes_pkg::fdes_result_t result
);
    import fdes_pkg::*;

    // A stalled result beat stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Only a found entry carries entry details.
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_FOUND) |->
            (result.found_cluster == '0) && (result.found_offset == '0) &&
            (result.file_kind == '0) && (result.first_cluster == '0) &&
            (result.found_size == '0))
        else $error("entry details on a beat that is not found");

    // A found entry has been counted.
    a_found_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_FOUND) |-> result.bytes_moved >= ENTRY_BYTES)
        else $error("found entry without its bytes counted");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.file_kind != 2'd3)
        else $error("file kind out of range");

endmodule

bind fat_directory_entry_scanner_core fdes_checker u_fdes_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: verif/tb_fat_directory_entry_scanner_core.sv
`timescale 1ns / 100ps

module tb_fat_directory_entry_scanner_core;
    import fdes_pkg::*;

    // Markers in the first name byte of a directory entry.
    localparam logic [7:0] END_MARK  = 8'h00;
    localparam logic [7:0] FREE_MARK = 8'hE5;
    localparam logic [31:0] BYTES_PER_ENTRY = 32'd32;

    // The receiver holds off this long once, so that both pipeline stages fill.
    localparam int unsigned LONG_HOLD      = 150;
    // Cycles without any accepted beat or register access before giving up.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS    = 200;
    localparam int unsigned PHASE_COUNT    = 8;

    // Kinds of directory entry that the stimulus builds.
    typedef enum int unsigned {
        EK_END,
        EK_FREE,
        EK_MATCH,
        EK_NEAR,
        EK_OTHER
    } entry_kind_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         entry_valid;
    logic         entry_stall;
    fdes_entry_t  entry;
    logic         result_valid;
    logic         result_stall;
    fdes_result_t result;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic         pready;

    fat_directory_entry_scanner_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (entry_valid),
        .entry_stall  (entry_stall),
        .entry        (entry),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Search registers as the block should hold them, starting from reset values.
    logic [63:0] cfg_name_body   = 64'h2020_2020_2020_2020;
    logic [23:0] cfg_name_suffix = 24'h20_2020;
    logic        cfg_match_any   = 1'b1;

    // Running search state of the scanner.
    logic [31:0] scan_byte_count  = '0;
    logic        scan_search_over = 1'b0;

    fdes_entry_t  pending_entries[$];
    fdes_result_t expected_results[$];

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned errors         = 0;
    int unsigned quiet_cycles   = 0;

    // Set by the monitor at the edge that takes an entry beat, cleared by the driver.
    bit          entry_taken   = 1'b0;
    // Random gaps on both channels are switched off for some phases.
    bit          idle_enable   = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned send_gap      = 0;
    int unsigned stall_left    = 0;

    // Works out the status beat for one entry and advances the search state.
    function automatic fdes_result_t scan_entry(input fdes_entry_t e);
        fdes_result_t r;
        logic [7:0]   lead;
        r = '0;
        lead = e.entry_name_body[63:56];
        if (e.first_of_search)
        begin
            scan_byte_count  = '0;
            scan_search_over = 1'b0;
        end
        if (scan_search_over)
        begin
            r.status = ST_IDLE;
        end
        else if (lead == END_MARK)
        begin
            r.status = ST_END;
            scan_search_over = 1'b1;
        end
        else
        begin
            // Every entry that is passed over or found adds its 32 bytes, saturating.
            if (scan_byte_count > 32'hFFFF_FFFF - BYTES_PER_ENTRY)
                scan_byte_count = 32'hFFFF_FFFF;
            else
                scan_byte_count = scan_byte_count + BYTES_PER_ENTRY;
            if (lead == FREE_MARK)
            begin
                r.status = ST_FREE;
            end
            else if (cfg_match_any || (e.entry_name_body == cfg_name_body &&
                                       e.entry_name_suffix == cfg_name_suffix))
            begin
                r.status = ST_FOUND;
                scan_search_over = 1'b1;
                r.found_cluster = e.holding_cluster;
                // A 16-bit offset already lies within a 64 KiB cluster.
                r.found_offset  = e.entry_offset;
                // The volume label bit wins over the directory bit.
                if (e.attributes[3])
                    r.file_kind = KIND_VOLUME;
                else if (e.attributes[4])
                    r.file_kind = KIND_DIR;
                else
                    r.file_kind = KIND_FILE;
                r.first_cluster = {e.start_cluster_high, e.start_cluster_low};
                r.found_size    = e.entry_file_size;
            end
            else
            begin
                r.status = ST_NO_MATCH;
            end
        end
        r.bytes_moved = scan_byte_count;
        return r;
    endfunction

    // Mostly back to back, sometimes a short gap, now and then a long gap.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (!idle_enable || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 10);
    endfunction

    function automatic fdes_entry_t make_entry(input entry_kind_t kind, input bit first);
        fdes_entry_t e;
        logic [87:0] name;
        e.first_of_search    = first;
        e.entry_name_body    = {$urandom(), $urandom()};
        e.entry_name_suffix  = 24'($urandom());
        e.attributes         = 8'($urandom());
        e.start_cluster_high = 16'($urandom());
        e.start_cluster_low  = 16'($urandom());
        e.entry_file_size    = $urandom();
        e.holding_cluster    = 28'($urandom());
        e.entry_offset       = 16'($urandom());
        case (kind)
            EK_END:   e.entry_name_body[63:56] = END_MARK;
            EK_FREE:  e.entry_name_body[63:56] = FREE_MARK;
            EK_MATCH:
            begin
                e.entry_name_body   = cfg_name_body;
                e.entry_name_suffix = cfg_name_suffix;
            end
            EK_NEAR:
            begin
                // The wanted name with exactly one bit flipped.
                name = {cfg_name_body, cfg_name_suffix} ^ (88'd1 << $urandom_range(87));
                {e.entry_name_body, e.entry_name_suffix} = name;
            end
            default:
            begin
                if (e.entry_name_body[63:56] == END_MARK ||
                    e.entry_name_body[63:56] == FREE_MARK)
                    e.entry_name_body[63:56] = 8'h41;
            end
        endcase
        return e;
    endfunction

    task automatic queue_entry(input fdes_entry_t e);
        pending_entries.push_back(e);
        queued_count++;
    endtask

    // One search: a first entry, entries that are passed over, then a match or
    // an end marker and a few entries that should come back idle. A tenth of the
    // searches are noise, and some lack their closing entry.
    task automatic queue_search(output int unsigned n);
        int unsigned len;
        int unsigned r;
        int unsigned k;
        entry_kind_t kind;
        len = ($urandom_range(19) == 0) ? $urandom_range(30, 10) : $urandom_range(8, 1);
        r = $urandom_range(9);
        n = 0;
        if (r == 0)
        begin
            for (k = 0; k < len; k++)
            begin
                queue_entry(make_entry(entry_kind_t'($urandom_range(4)),
                                       $urandom_range(3) == 0));
                n++;
            end
        end
        else
        begin
            for (k = 0; k < len; k++)
            begin
                if (k == len - 1 && r != 1)
                    kind = ($urandom_range(3) == 0) ? EK_END : EK_MATCH;
                else
                    kind = entry_kind_t'($urandom_range(EK_OTHER, EK_FREE));
                if (kind == EK_MATCH && k != len - 1)
                    kind = EK_NEAR;
                queue_entry(make_entry(kind, k == 0));
                n++;
            end
            for (k = $urandom_range(2); k > 0; k--)
            begin
                queue_entry(make_entry(entry_kind_t'($urandom_range(4)), 1'b0));
                n++;
            end
        end
    endtask

    // Waits until every queued entry was taken and every status beat came back.
    task automatic drain(input int unsigned settle);
        while (accepted_count != queued_count || expected_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic cfg_write(input fdes_reg_t idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_NAME_BODY:   cfg_name_body   = value;
            REG_NAME_SUFFIX: cfg_name_suffix = value[23:0];
            default:         cfg_match_any   = value[0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_readback(input fdes_reg_t idx, input logic [63:0] want);
        logic [63:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            $error("register %s: expected %0h, got %0h", idx.name(), want, got);
            errors++;
        end
    endtask

    task automatic program_search(input logic [63:0] body, input logic [23:0] suffix,
                                  input bit any);
        cfg_write(REG_NAME_BODY, body);
        cfg_write(REG_NAME_SUFFIX, {40'd0, suffix});
        cfg_write(REG_MATCH_ANY, {63'd0, any});
        cfg_readback(REG_NAME_BODY, body);
        cfg_readback(REG_NAME_SUFFIX, {40'd0, suffix});
        cfg_readback(REG_MATCH_ANY, {63'd0, any});
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Driver: a new beat goes out at the falling edge once the previous one was
    // taken; a stalled beat stays as it is.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            entry_valid <= 1'b0;
        end
        else if (!entry_valid || entry_taken)
        begin
            if (send_gap != 0)
            begin
                entry_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_entries.size() != 0)
            begin
                entry       <= pending_entries.pop_front();
                entry_valid <= 1'b1;
                send_gap    = pick_gap();
            end
            else
            begin
                entry_valid <= 1'b0;
            end
        end
        entry_taken = 1'b0;
    end

    // Receiver: random stall stretches, plus the one long hold-off on request.
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            stall_left    = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        else if (stall_left == 0 && $urandom_range(2) == 0)
        begin
            stall_left = pick_gap();
        end
        if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Monitor: predicts each entry beat as it is taken, then checks each status
    // beat against the oldest prediction. The watchdog runs here as well.
    always @(posedge clk)
    begin : monitor
        fdes_result_t want;
        bit           active;
        active = 1'b0;
        if (rst_n)
        begin
            if (entry_valid && !entry_stall)
            begin
                expected_results.push_back(scan_entry(entry));
                accepted_count++;
                entry_taken = 1'b1;
                active = 1'b1;
            end
            if (result_valid && !result_stall)
            begin
                active = 1'b1;
                if (expected_results.size() == 0)
                begin
                    $error("status beat %0h arrived with nothing expected", result);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, result.status);
                    check_field("bytes_moved", want.bytes_moved, result.bytes_moved);
                    check_field("found_cluster", want.found_cluster, result.found_cluster);
                    check_field("found_offset", want.found_offset, result.found_offset);
                    check_field("file_kind", want.file_kind, result.file_kind);
                    check_field("first_cluster", want.first_cluster, result.first_cluster);
                    check_field("found_size", want.found_size, result.found_size);
                end
            end
            if (psel && penable && pready)
                active = 1'b1;
            quiet_cycles = active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        fdes_entry_t e;
        int unsigned p;
        int unsigned n;
        int unsigned phase_items;
        logic [63:0] body;
        logic [23:0] suffix;
        bit          any;

        rst_n        = 1'b0;
        entry_valid  = 1'b0;
        entry        = '0;
        result_stall = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset registers: match any used entry.
        // Found entry with every field at its top and both kind bits set.
        e = make_entry(EK_MATCH, 1'b1);
        e.attributes         = 8'h18;
        e.start_cluster_high = 16'hFFFF;
        e.start_cluster_low  = 16'hFFFF;
        e.entry_file_size    = 32'hFFFF_FFFF;
        e.holding_cluster    = 28'hFFF_FFFF;
        e.entry_offset       = 16'hFFFF;
        queue_entry(e);
        // After a match the search stays idle.
        queue_entry(make_entry(EK_OTHER, 1'b0));
        // An all-zero first entry is an end marker.
        e = '0;
        e.first_of_search = 1'b1;
        queue_entry(e);
        queue_entry(make_entry(EK_FREE, 1'b0));
        // A free entry is skipped, then a directory with its fields at zero.
        queue_entry(make_entry(EK_FREE, 1'b1));
        e = make_entry(EK_OTHER, 1'b0);
        e.attributes         = 8'h10;
        e.start_cluster_high = '0;
        e.start_cluster_low  = '0;
        e.entry_file_size    = '0;
        e.holding_cluster    = '0;
        e.entry_offset       = '0;
        queue_entry(e);
        drain(4);

        // Look for one particular short name.
        program_search(64'h5245_4144_4D45_2020, 24'h54_5854, 1'b0);
        queue_entry(make_entry(EK_OTHER, 1'b1));
        queue_entry(make_entry(EK_NEAR, 1'b0));
        queue_entry(make_entry(EK_NEAR, 1'b0));
        queue_entry(make_entry(EK_FREE, 1'b0));
        e = make_entry(EK_MATCH, 1'b0);
        e.attributes = 8'h00;
        queue_entry(e);
        queue_entry(make_entry(EK_MATCH, 1'b0));
        e = make_entry(EK_MATCH, 1'b1);
        e.attributes = 8'h08;
        queue_entry(e);
        queue_entry(make_entry(EK_FREE, 1'b1));
        queue_entry(make_entry(EK_END, 1'b0));
        queue_entry(make_entry(EK_OTHER, 1'b0));
        queue_entry(make_entry(EK_END, 1'b1));
        drain(4);

        // Random phases, each under its own search registers. The first two use
        // the extremes; phase two also runs without gaps and with the long
        // receiver hold-off. Between phases the sender waits for every result.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    body   = '1;
                    suffix = '1;
                    any    = 1'b0;
                end
                1:
                begin
                    body   = '0;
                    suffix = '0;
                    any    = 1'b0;
                end
                default:
                begin
                    body   = {$urandom(), $urandom()};
                    suffix = 24'($urandom());
                    any    = (p == 2 || p == 6);
                    if (body[63:56] == END_MARK || body[63:56] == FREE_MARK)
                        body[63:56] = 8'h46;
                end
            endcase
            program_search(body, suffix, any);
            idle_enable = (p != 2 && p != 5);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                queue_search(n);
                phase_items += n;
            end
            if (p == 2)
            begin
                @(posedge clk);
                long_hold_req = 1'b1;
            end
            drain(4);
        end

        drain(10);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
